FILE: rtl/bal_pkg.sv
// ----------------------------------------------------------------------------
// bal_pkg: shared types and codes for the bounded array list
// Holds the request and result transaction structs and the operation codes.
// ----------------------------------------------------------------------------
package bal_pkg;

  localparam int MODE_W  = 3;
  localparam int INDEX_W = 5;
  localparam int ITEM_W  = 32;
  localparam int COUNT_W = 5;

  localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_GET    = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] index;
    logic [ITEM_W-1:0]  item;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic [ITEM_W-1:0]  read_item;
    logic [COUNT_W-1:0] count;
    logic               full_res;
    logic               empty_res;
  } out_item_t;

endpackage

FILE: rtl/bal_ram.sv
// ----------------------------------------------------------------------------
// bal_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module bal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/bounded_array_list.sv
// ----------------------------------------------------------------------------
// bounded_array_list: fixed-capacity ordered list of words
// Push, pop, insert, remove and get on a list held in one RAM, with a count.
// ----------------------------------------------------------------------------
//
//   channel   ports                           direction   payload
//   request   in_valid / in_ready / in_data   in          in_item_t
//   result    out_valid / out_ready / out_data out        out_item_t
//
// One request is worked on at a time. Push, pop and refused requests go
// from the accept straight to S_DONE, get takes its entry from the RAM in
// S_GET, and insert and remove move m entries in S_SHIFT (count - index for
// insert, count - index - 1 for remove), so at most CAPACITY - 1 for an
// insert at the front of a list one short of full; an insert then writes
// its word. The shift loop moves one entry per cycle through the RAM's
// single read and single write port.
// Reset (synchronous, active low) clears the count and the control state;
// the RAM contents are left as they are and are only read below the count.
// A result that is not taken waits in the output register while the next
// request is accepted and worked on; only its completion waits.
module bounded_array_list
  import bal_pkg::*;
#(
  parameter int CAPACITY  = 16,
  parameter int ITEM_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // Address and count widths follow from the capacity; the compare width is the wider of the count width and INDEX_W.
  localparam int AW        = $clog2(CAPACITY);
  localparam int CW        = $clog2(CAPACITY + 1);
  localparam int XW        = (CW > INDEX_W) ? CW : INDEX_W;
  localparam int WORD_BITS = (ITEM_BITS < ITEM_W) ? ITEM_BITS : ITEM_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SHIFT = 4'b0010,
    S_GET   = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       held_r, held_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_r, out_nxt;

  // Pending result of the request in flight.
  logic                res_ok_r, res_ok_nxt;
  logic [ITEM_W-1:0]   res_item_r, res_item_nxt;

  // Shift sequencer.
  logic [AW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]       left_r, left_nxt;
  logic                rvld_r, rvld_nxt;
  logic                up_r, up_nxt;
  logic                fin_r, fin_nxt;
  logic [AW-1:0]       fin_addr_r, fin_addr_nxt;
  logic [WORD_BITS-1:0] word_r, word_nxt;

  // RAM ports.
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // Request decode against the current count.
  logic [XW-1:0]       held_x, idx_x;
  logic                not_full, not_empty, idx_lt, idx_le;
  logic [WORD_BITS-1:0] word_in;

  bal_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign held_x    = XW'(held_r);
  assign idx_x     = XW'(in_data.index);
  assign not_full  = (held_r != CW'(CAPACITY));
  assign not_empty = (held_r != '0);
  assign idx_lt    = (idx_x < held_x);
  assign idx_le    = (idx_x <= held_x);
  assign word_in   = WORD_BITS'(in_data.item);

  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    res_ok_nxt    = res_ok_r;
    res_item_nxt  = res_item_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    left_nxt      = left_r;
    rvld_nxt      = 1'b0;
    up_nxt        = up_r;
    fin_nxt       = fin_r;
    fin_addr_nxt  = fin_addr_r;
    word_nxt      = word_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          // Every request ends in S_DONE; refused ones change nothing.
          res_ok_nxt   = 1'b0;
          res_item_nxt = '0;
          state_nxt    = S_DONE;
          unique case (in_data.mode)
            MODE_PUSH: begin
              if (not_full) begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(held_r);
                ram_wdata  = word_in;
                held_nxt   = held_r + CW'(1);
                res_ok_nxt = 1'b1;
              end
            end
            MODE_POP: begin
              if (not_empty) begin
                held_nxt   = held_r - CW'(1);
                res_ok_nxt = 1'b1;
              end
            end
            MODE_INSERT: begin
              // Move entries index..count-1 up by one, from the top down,
              // then write the new word at index.
              if (not_full && idx_le) begin
                res_ok_nxt   = 1'b1;
                state_nxt    = S_SHIFT;
                up_nxt       = 1'b0;
                rd_ptr_nxt   = AW'(held_x - XW'(1));
                wr_ptr_nxt   = AW'(held_r);
                left_nxt     = CW'(held_x - idx_x);
                fin_nxt      = 1'b1;
                fin_addr_nxt = AW'(in_data.index);
                word_nxt     = word_in;
                held_nxt     = held_r + CW'(1);
              end
            end
            MODE_REMOVE: begin
              // Move entries index+1..count-1 down by one, bottom up.
              if (idx_lt) begin
                res_ok_nxt = 1'b1;
                state_nxt  = S_SHIFT;
                up_nxt     = 1'b1;
                rd_ptr_nxt = AW'(idx_x + XW'(1));
                wr_ptr_nxt = AW'(in_data.index);
                left_nxt   = CW'(held_x - idx_x - XW'(1));
                fin_nxt    = 1'b0;
                held_nxt   = held_r - CW'(1);
              end
            end
            MODE_GET: begin
              if (idx_lt) begin
                res_ok_nxt = 1'b1;
                ram_raddr  = AW'(in_data.index);
                state_nxt  = S_GET;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SHIFT: begin
        // Reads run one entry ahead of writes; the write address is always
        // two entries away from the read address, so they never meet.
        if (left_r != '0) begin
          ram_raddr  = rd_ptr_r;
          rd_ptr_nxt = up_r ? rd_ptr_r + AW'(1) : rd_ptr_r - AW'(1);
          left_nxt   = left_r - CW'(1);
          rvld_nxt   = 1'b1;
        end
        if (rvld_r) begin
          ram_we     = 1'b1;
          ram_waddr  = wr_ptr_r;
          ram_wdata  = ram_rdata;
          wr_ptr_nxt = up_r ? wr_ptr_r + AW'(1) : wr_ptr_r - AW'(1);
        end else if (left_r == '0) begin
          if (fin_r) begin
            ram_we    = 1'b1;
            ram_waddr = fin_addr_r;
            ram_wdata = word_r;
          end
          state_nxt = S_DONE;
        end
      end

      S_GET: begin
        res_item_nxt = ITEM_W'(ram_rdata);
        state_nxt    = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.ok        = res_ok_r;
          out_nxt.read_item = res_item_r;
          out_nxt.count     = COUNT_W'(held_r);
          out_nxt.full_res  = (held_r == CW'(CAPACITY));
          out_nxt.empty_res = (held_r == '0);
          out_valid_nxt     = 1'b1;
          state_nxt         = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      out_valid_r <= 1'b0;
      rvld_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
      rvld_r      <= rvld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r      <= out_nxt;
    res_ok_r   <= res_ok_nxt;
    res_item_r <= res_item_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    wr_ptr_r   <= wr_ptr_nxt;
    left_r     <= left_nxt;
    up_r       <= up_nxt;
    fin_r      <= fin_nxt;
    fin_addr_r <= fin_addr_nxt;
    word_r     <= word_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // An accepted request always takes the block out of the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while previous one still in flight");

  // During a shift the write never lands on the entry being read.
  a_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && ram_we && left_r != '0) |-> (ram_waddr != ram_raddr))
    else $error("shift write collides with shift read");

  // The count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CW'(CAPACITY))
    else $error("count above capacity");

  // A freshly loaded result reports the count then held.
  a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && state_nxt == S_IDLE)
      |=> (out_data.count == COUNT_W'(held_r)))
    else $error("result count does not match list count");

  // A result is never both full and empty.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.full_res && out_data.empty_res))
    else $error("full and empty flags both set");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the bounded array list
// Drives push, pop, insert, remove and get requests through the valid/ready
// request channel, predicts every result with a behavioral copy of the list,
// and compares each result transaction field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb;
  import bal_pkg::*;

  localparam int LIST_DEPTH   = 16;
  localparam int MAX_GAP      = 6;
  localparam int RANDOM_ITEMS = 1300;
  localparam int PHASE_ITEMS  = 120;
  // The slowest request is an insert at index 0 of a nearly full list; the
  // drain wait at the end is longer than that request takes.
  localparam int DRAIN_CYCLES = 40;
  // Roughly 1450 requests, each allowed the slowest case above, with a wide
  // margin on top.
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic [MODE_W-1:0]  MODE_TOP  = '1;
  localparam logic [INDEX_W-1:0] INDEX_TOP = '1;
  localparam logic [ITEM_W-1:0]  WORD_ONES = '1;
  localparam logic [ITEM_W-1:0]  WORD_ZERO = '0;

  // Behavioral list with its own count. predict() applies one request and
  // returns the result transaction that the block must produce for it.
  class list_scoreboard;
    logic [ITEM_W-1:0] slots [LIST_DEPTH];
    int unsigned held;
    out_item_t   expected_q [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned granted [1 << MODE_W];
    int unsigned refused;
    int unsigned full_seen;
    int unsigned empty_seen;

    function new();
      held       = 0;
      errors     = 0;
      checked    = 0;
      refused    = 0;
      full_seen  = 0;
      empty_seen = 0;
      foreach (granted[m]) granted[m] = 0;
    endfunction

    function out_item_t predict(in_item_t req);
      out_item_t   res;
      int unsigned pos;
      int unsigned k;
      res = '0;
      pos = req.index;
      case (req.mode)
        MODE_PUSH: begin
          if (held < LIST_DEPTH) begin
            slots[held] = req.item;
            held++;
            res.ok = 1'b1;
          end
        end
        MODE_POP: begin
          if (held > 0) begin
            held--;
            res.ok = 1'b1;
          end
        end
        MODE_INSERT: begin
          if (held < LIST_DEPTH && pos <= held) begin
            for (k = held; k > pos; k--) slots[k] = slots[k-1];
            slots[pos] = req.item;
            held++;
            res.ok = 1'b1;
          end
        end
        MODE_REMOVE: begin
          if (pos < held) begin
            for (k = pos; k + 1 < held; k++) slots[k] = slots[k+1];
            held--;
            res.ok = 1'b1;
          end
        end
        MODE_GET: begin
          if (pos < held) begin
            res.read_item = slots[pos];
            res.ok        = 1'b1;
          end
        end
        default: ;
      endcase
      res.count     = COUNT_W'(held);
      res.full_res  = (held == LIST_DEPTH);
      res.empty_res = (held == 0);
      return res;
    endfunction

    function void note_request(in_item_t req);
      out_item_t res;
      res = predict(req);
      expected_q.push_back(res);
      if (res.ok) granted[req.mode]++;
      else refused++;
      if (res.full_res) full_seen++;
      if (res.empty_res) empty_seen++;
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding: %h", got);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      if (got.ok !== exp.ok) begin
        $error("ok: expected %0b, got %0b", exp.ok, got.ok);
        errors++;
      end
      if (got.read_item !== exp.read_item) begin
        $error("read_item: expected %h, got %h", exp.read_item, got.read_item);
        errors++;
      end
      if (got.count !== exp.count) begin
        $error("count: expected %0d, got %0d", exp.count, got.count);
        errors++;
      end
      if (got.full_res !== exp.full_res) begin
        $error("full_res: expected %0b, got %0b", exp.full_res, got.full_res);
        errors++;
      end
      if (got.empty_res !== exp.empty_res) begin
        $error("empty_res: expected %0b, got %0b", exp.empty_res, got.empty_res);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // When set, neither side inserts idle cycles, so the block runs back to back.
  bit          quiet_phase = 1'b0;
  int unsigned cycle_cnt = 0;
  int unsigned sent = 0;

  // The board sees transactions as the block sees them and does all checking.
  // The planner is a second list that the request generator alone uses to
  // know the current count without racing the monitor at the same clock edge.
  list_scoreboard board;
  list_scoreboard planner;

  bounded_array_list #(
    .CAPACITY (LIST_DEPTH),
    .ITEM_BITS(ITEM_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // A hung handshake ends the run here.
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("tb failed");
    $finish;
  end

  // Monitor. Values read at the rising edge are the ones the block sampled,
  // since every driver updates with nonblocking assignments. A result is
  // checked before a request taken at the same edge is noted, so a stray
  // result can never match the request that was only just accepted.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_result(out_data);
    end
    if (rst_n && in_valid && in_ready) begin
      board.note_request(in_data);
    end
  end

  // Result side: before each result transaction the receiver stalls for a
  // random number of cycles, which lands ready low both before and while a
  // result waits in the output register.
  initial begin : result_side
    int unsigned stall;
    out_ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = quiet_phase ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Sends one request transaction after a random gap. The task returns at
  // the edge where the transaction was taken; valid is touched at most once
  // per edge, so back-to-back requests keep valid high without a glitch.
  task automatic send_request(input in_item_t req);
    int unsigned gap;
    gap = quiet_phase ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    void'(planner.predict(req));
    sent++;
  endtask

  task automatic send_fields(input logic [MODE_W-1:0] mode,
                             input logic [INDEX_W-1:0] index,
                             input logic [ITEM_W-1:0] item);
    in_item_t req;
    req.mode  = mode;
    req.index = index;
    req.item  = item;
    send_request(req);
  endtask

  // Stops sending and waits, sampling on the falling edge to stay clear of
  // the monitor, until every result predicted so far has been checked.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (board.pending() != 0);
    @(posedge clk);
  endtask

  function automatic logic [ITEM_W-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return WORD_ZERO;
    if (r == 1) return WORD_ONES;
    return ITEM_W'($urandom);
  endfunction

  // Builds one request. grow_pct and read_pct set the share of push/insert
  // and of get; a small share uses the unused codes and the rest shrink the
  // list. Most indexes are in range for the current count, some sit right on
  // the boundary, and a few take any value the field can hold.
  function automatic in_item_t pick_request(int unsigned grow_pct,
                                            int unsigned read_pct);
    in_item_t    req;
    int unsigned roll;
    int unsigned count_now;
    int unsigned r;
    count_now = planner.held;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      req.mode = MODE_W'($urandom_range(MODE_GET + 1, MODE_TOP));
    end else if (roll < 3 + grow_pct) begin
      req.mode = $urandom_range(0, 1) ? MODE_PUSH : MODE_INSERT;
    end else if (roll < 3 + grow_pct + read_pct) begin
      req.mode = MODE_GET;
    end else begin
      req.mode = $urandom_range(0, 1) ? MODE_POP : MODE_REMOVE;
    end
    r = $urandom_range(0, 9);
    if (r == 0) begin
      req.index = INDEX_W'($urandom_range(0, INDEX_TOP));
    end else if (r == 1 || count_now == 0) begin
      req.index = INDEX_W'(count_now);
    end else if (req.mode == MODE_INSERT) begin
      req.index = INDEX_W'($urandom_range(0, count_now));
    end else begin
      req.index = INDEX_W'($urandom_range(0, count_now - 1));
    end
    req.item = pick_word();
    return req;
  endfunction

  // Fills the list to capacity with random words, probes the edges of a
  // full list, then empties it by removals at random positions.
  task automatic fill_and_empty();
    while (planner.held < LIST_DEPTH) begin
      if ($urandom_range(0, 1)) begin
        send_fields(MODE_PUSH, INDEX_W'($urandom), pick_word());
      end else begin
        send_fields(MODE_INSERT, INDEX_W'($urandom_range(0, planner.held)), pick_word());
      end
    end
    send_fields(MODE_PUSH, '0, pick_word());
    send_fields(MODE_INSERT, '0, pick_word());
    send_fields(MODE_INSERT, INDEX_W'(LIST_DEPTH), pick_word());
    send_fields(MODE_GET, INDEX_W'(LIST_DEPTH - 1), '0);
    send_fields(MODE_GET, INDEX_W'(LIST_DEPTH), '0);
    send_fields(MODE_REMOVE, INDEX_W'(LIST_DEPTH), '0);
    send_fields(MODE_REMOVE, '0, '0);
    send_fields(MODE_INSERT, '0, pick_word());
    while (planner.held > 0) begin
      send_fields(MODE_REMOVE, INDEX_W'($urandom_range(0, planner.held - 1)), '0);
    end
  endtask

  initial begin : stimulus
    int unsigned grow_pct;
    int unsigned read_pct;
    int unsigned phase;
    int unsigned n;
    board   = new();
    planner = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests on a fresh list: pop, get, remove and an out-of-range
    // insert refused on empty, inserts at the front, in the middle and at the
    // end, reads at each position and just past the end, removal of the last
    // and first entries, the unused operation codes, and pops whose index is ignored.
    send_fields(MODE_POP, '0, '0);
    send_fields(MODE_GET, '0, '0);
    send_fields(MODE_REMOVE, '0, '0);
    send_fields(MODE_INSERT, INDEX_W'(1), WORD_ONES);
    send_fields(MODE_INSERT, '0, WORD_ONES);
    send_fields(MODE_PUSH, INDEX_TOP, WORD_ZERO);
    send_fields(MODE_INSERT, INDEX_W'(2), 32'hA5A5_A5A5);
    send_fields(MODE_INSERT, INDEX_W'(1), 32'h5A5A_5A5A);
    send_fields(MODE_GET, INDEX_W'(0), '0);
    send_fields(MODE_GET, INDEX_W'(1), '0);
    send_fields(MODE_GET, INDEX_W'(2), '0);
    send_fields(MODE_GET, INDEX_W'(3), '0);
    send_fields(MODE_GET, INDEX_W'(4), '0);
    send_fields(MODE_GET, INDEX_TOP, '0);
    send_fields(MODE_REMOVE, INDEX_W'(3), '0);
    send_fields(MODE_REMOVE, INDEX_W'(0), '0);
    send_fields(MODE_REMOVE, INDEX_W'(LIST_DEPTH), '0);
    for (n = MODE_GET + 1; n <= MODE_TOP; n++) begin
      send_fields(MODE_W'(n), INDEX_W'(1), WORD_ONES);
    end
    send_fields(MODE_POP, '0, '0);
    send_fields(MODE_POP, INDEX_TOP, WORD_ONES);
    send_fields(MODE_POP, '0, '0);
    hold_until_drained();

    fill_and_empty();
    hold_until_drained();

    // Random part in phases that lean toward filling, draining, mixed use
    // and reading. Between phases the sender waits for every outstanding
    // result, and some phases run with no idle cycles on either side.
    phase = 0;
    n = 0;
    while (n < RANDOM_ITEMS) begin
      case (phase % 4)
        0:       begin grow_pct = 60; read_pct = 15; end
        1:       begin grow_pct = 15; read_pct = 15; end
        2:       begin grow_pct = 35; read_pct = 30; end
        default: begin grow_pct = 25; read_pct = 50; end
      endcase
      quiet_phase = ($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) begin
        if (n < RANDOM_ITEMS) begin
          send_request(pick_request(grow_pct, read_pct));
          n++;
        end
      end
      hold_until_drained();
      if (phase % 5 == 4) begin
        fill_and_empty();
        hold_until_drained();
      end
      phase++;
    end
    quiet_phase = 1'b0;

    in_valid <= 1'b0;
    do @(negedge clk); while (board.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests, %0d results checked.", sent, board.checked);
    $display("Granted push %0d, pop %0d, insert %0d, remove %0d, get %0d; refused %0d.",
             board.granted[MODE_PUSH], board.granted[MODE_POP],
             board.granted[MODE_INSERT], board.granted[MODE_REMOVE],
             board.granted[MODE_GET], board.refused);
    $display("The list was left full by %0d requests and empty by %0d.",
             board.full_seen, board.empty_seen);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/bal_pkg.sv
rtl/bal_ram.sv
rtl/bounded_array_list.sv
tb/tb.sv
